// File: rtl/fmv_pkg.sv
// shared constants, register indexes and sine table contents for the fm voice
package fmv_pkg;

    localparam int unsigned TABLE_SIZE_DEF  = 1024;
    localparam int unsigned SAMPLE_BITS_DEF = 16;
    localparam int unsigned MAX_SAMPLE_BITS = 24;

    localparam int unsigned BASE_W  = 31;
    localparam int unsigned MULT_W  = 16;
    localparam int unsigned DEPTH_W = 20;
    localparam int unsigned LEVEL_W = 16;
    localparam int unsigned PHASE_W = 32;
    localparam int unsigned OUT_W   = 16;
    localparam int unsigned CFG_W   = 20;
    localparam int unsigned CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MULT_OP2     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MULT_OP3     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MULT_OP4     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_PAIR_A = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_PAIR_B = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_OP1    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_OP3    = 3'd6;

    localparam logic [MULT_W-1:0]  MULT_UNITY  = 16'd256;
    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 16'd32768;

    // phase memory entries
    localparam logic [1:0] OP1 = 2'd0;
    localparam logic [1:0] OP2 = 2'd1;
    localparam logic [1:0] OP3 = 2'd2;
    localparam logic [1:0] OP4 = 2'd3;

    localparam logic [OUT_W-1:0] SAMPLE_MAX = 16'h7FFF;
    localparam logic [OUT_W-1:0] SAMPLE_MIN = 16'h8000;

    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // sine of one table phase (2^32 is a full turn), q30 horner series,
    // scaled to the peak of the sample width
    function automatic logic signed [MAX_SAMPLE_BITS-1:0] sine_value(
        input logic [31:0] q,
        input int unsigned sample_bits
    );
        logic [63:0] amp;
        logic [63:0] frac;
        logic [63:0] u;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] mag;
        logic [63:0] res;
        amp  = (64'd1 << (sample_bits - 1)) - 64'd1;
        frac = {34'd0, q[29:0]};
        u    = q[30] ? (Q30_ONE - frac) : frac;
        x    = (u * HALF_PI_Q30) >> 30;
        x2   = (x * x) >> 30;
        t    = Q30_ONE;
        t    = Q30_ONE - (((x2 * t) >> 30) / 64'd110);
        t    = Q30_ONE - (((x2 * t) >> 30) / 64'd72);
        t    = Q30_ONE - (((x2 * t) >> 30) / 64'd42);
        t    = Q30_ONE - (((x2 * t) >> 30) / 64'd20);
        t    = Q30_ONE - (((x2 * t) >> 30) / 64'd6);
        s    = (x * t) >> 30;
        mag  = (s * amp + (64'd1 << 29)) >> 30;
        if (mag > amp) begin
            mag = amp;
        end
        res = q[31] ? (64'd0 - mag) : mag;
        return res[MAX_SAMPLE_BITS-1:0];
    endfunction

endpackage

// File: rtl/four_operator_fm_voice.sv
// four-operator fm voice: two modulator/carrier pairs over a shared phase memory
//
// Each input request carries the base phase step of one sample tick and yields
// exactly one output request with the mixed sample. Operator 2 modulates
// operator 1 and operator 4 modulates operator 3. The four 32-bit phases live
// in a small synchronous memory that is read, advanced and written back one
// operator at a time, in the order 2, 1, 4, 3. One shared multiplier (32 by
// 25 bits, registered) handles the frequency multipliers, the modulation
// depths and the carrier levels, and the sine comes from a constant table
// with a registered read. A tick walks ten steps per pair plus one rounding
// step, and no new request is taken until the tick is done; o_stall stays
// high while a tick is in flight. The finished sample sits in an output
// register, so the next tick runs while the previous one waits to be taken,
// and only the rounding step waits on a full output register. Configuration
// writes land at once and must only be issued while no tick is in flight.
// The phases read as zero after reset without any clearing pass.
module four_operator_fm_voice #(
    parameter int unsigned TABLE_SIZE  = fmv_pkg::TABLE_SIZE_DEF,
    parameter int unsigned SAMPLE_BITS = fmv_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [fmv_pkg::BASE_W-1:0]        i_base_increment,
    // output channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [fmv_pkg::OUT_W-1:0]  o_sample,
    // configuration writes
    input  logic                              i_cfg_wr_en,
    input  logic [fmv_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fmv_pkg::CFG_W-1:0]         i_cfg_data
);

    localparam int unsigned IDX_W   = $clog2(TABLE_SIZE);
    localparam int unsigned IP_W    = fmv_pkg::PHASE_W + IDX_W + 1;
    localparam int unsigned MUL_A_W = fmv_pkg::PHASE_W;
    localparam int unsigned MUL_B_W = fmv_pkg::MAX_SAMPLE_BITS + 1;
    localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
    // two level-scaled sines plus rounding headroom
    localparam int unsigned ACC_W   = SAMPLE_BITS + fmv_pkg::LEVEL_W + 3;
    localparam int unsigned RND_W   = ACC_W - SAMPLE_BITS;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MINC,   // modulator increment product
        ST_MPH,    // modulator phase update and write back
        ST_MIDX,   // modulator table index, carrier increment product
        ST_MSIN,   // modulator sine read, carrier phase plus increment
        ST_DEP,    // depth times modulator sine
        ST_CPH,    // carrier phase update and write back
        ST_CIDX,   // carrier table index
        ST_CSIN,   // carrier sine read
        ST_LVL,    // level times carrier sine
        ST_ACC,    // mix into accumulator
        ST_RND     // round, saturate, hand to output register
    } t_state;

    t_state r_state;

    // configuration registers
    logic [fmv_pkg::MULT_W-1:0]  r_mult_op2;
    logic [fmv_pkg::MULT_W-1:0]  r_mult_op3;
    logic [fmv_pkg::MULT_W-1:0]  r_mult_op4;
    logic [fmv_pkg::DEPTH_W-1:0] r_depth_pair_a;
    logic [fmv_pkg::DEPTH_W-1:0] r_depth_pair_b;
    logic [fmv_pkg::LEVEL_W-1:0] r_level_op1;
    logic [fmv_pkg::LEVEL_W-1:0] r_level_op3;

    // datapath registers
    logic                              r_pair;      // 0: operators 2/1, 1: operators 4/3
    logic [fmv_pkg::BASE_W-1:0]        r_base;
    logic [fmv_pkg::PHASE_W-1:0]       r_ph;
    logic [fmv_pkg::PHASE_W-1:0]       r_cph;
    logic [IDX_W-1:0]                  r_idx;
    logic signed [SAMPLE_BITS-1:0]     r_sin;
    logic signed [PROD_W-1:0]          r_prod;
    logic signed [ACC_W-1:0]           r_acc;
    logic                              r_out_vld;
    logic signed [fmv_pkg::OUT_W-1:0]  r_sample;

    // phase memory, four entries, one read and one write port
    logic [fmv_pkg::PHASE_W-1:0] r_mem [4];
    logic [fmv_pkg::PHASE_W-1:0] r_rdata;
    logic [3:0]                  r_ph_vld;   // entry written since reset
    logic                        r_rd_vld;

    logic                        w_accept;
    logic                        w_out_load;
    logic                        w_rd_en;
    logic [1:0]                  w_rd_addr;
    logic                        w_wr_en;
    logic [1:0]                  w_wr_addr;
    logic [fmv_pkg::PHASE_W-1:0] w_wr_data;
    logic [fmv_pkg::PHASE_W-1:0] w_rd_ph;

    logic                        w_mul_en;
    logic signed [MUL_A_W-1:0]   w_mul_a;
    logic signed [MUL_B_W-1:0]   w_mul_b;
    logic signed [PROD_W-1:0]    w_prod;

    logic [IP_W-1:0]             w_idx_prod;
    logic [IDX_W:0]              w_idx_full;
    logic [IDX_W-1:0]            w_idx;

    logic signed [ACC_W-1:0]     w_acc_next;
    logic signed [ACC_W-1:0]     w_acc_rnd;
    logic signed [RND_W-1:0]     w_rnd;
    logic [fmv_pkg::OUT_W-1:0]   w_sat;

    // sine table, built at elaboration
    logic signed [SAMPLE_BITS-1:0] w_sine [TABLE_SIZE];

    for (genvar gi = 0; gi < TABLE_SIZE; gi++) begin : g_sine
        localparam logic [63:0] TAB_PHASE = (64'(gi) << 32) / 64'(TABLE_SIZE);
        localparam logic signed [fmv_pkg::MAX_SAMPLE_BITS-1:0] TAB_VAL =
            fmv_pkg::sine_value(TAB_PHASE[31:0], SAMPLE_BITS);
        assign w_sine[gi] = TAB_VAL[SAMPLE_BITS-1:0];
    end

    assign w_accept = i_valid && (r_state == ST_IDLE);
    assign o_stall  = (r_state != ST_IDLE);
    assign o_valid  = r_out_vld;
    assign o_sample = r_sample;

    // rounding step may load the output register once it is free or being taken
    assign w_out_load = (r_state == ST_RND) && (!r_out_vld || !i_stall);

    // memory access plan: modulator read ahead of its update, carrier read
    // during the modulator write back, next pair's modulator read at the mix
    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = fmv_pkg::OP2;
        w_wr_en   = 1'b0;
        w_wr_addr = r_pair ? fmv_pkg::OP4 : fmv_pkg::OP2;
        w_wr_data = r_ph;
        unique case (r_state)
            ST_IDLE: begin
                w_rd_en   = w_accept;
                w_rd_addr = fmv_pkg::OP2;
            end
            ST_MPH: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_pair ? fmv_pkg::OP3 : fmv_pkg::OP1;
                w_wr_en   = 1'b1;
                w_wr_addr = r_pair ? fmv_pkg::OP4 : fmv_pkg::OP2;
                w_wr_data = w_rd_ph + r_prod[39:8];
            end
            ST_CPH: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_pair ? fmv_pkg::OP3 : fmv_pkg::OP1;
                w_wr_data = r_cph + r_prod[33:2];
            end
            ST_ACC: begin
                w_rd_en   = !r_pair;
                w_rd_addr = fmv_pkg::OP4;
            end
            default: begin
            end
        endcase
    end

    assign w_rd_ph = r_rd_vld ? r_rdata : '0;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    // shared multiplier operand select
    always_comb begin
        w_mul_en = 1'b1;
        w_mul_a  = '0;
        w_mul_b  = '0;
        unique case (r_state)
            ST_MINC: begin
                w_mul_a = MUL_A_W'(r_base);
                w_mul_b = MUL_B_W'(r_pair ? r_mult_op4 : r_mult_op2);
            end
            ST_MIDX: begin
                // carrier 1 runs at the base step
                w_mul_a = MUL_A_W'(r_base);
                w_mul_b = MUL_B_W'(r_pair ? r_mult_op3 : fmv_pkg::MULT_UNITY);
            end
            ST_DEP: begin
                w_mul_a = MUL_A_W'(r_pair ? r_depth_pair_b : r_depth_pair_a);
                w_mul_b = MUL_B_W'(r_sin);
            end
            ST_LVL: begin
                w_mul_a = MUL_A_W'(r_pair ? r_level_op3 : r_level_op1);
                w_mul_b = MUL_B_W'(r_sin);
            end
            default: begin
                w_mul_en = 1'b0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // table index: round half up, an index at the table end wraps to zero
    assign w_idx_prod = IP_W'(r_ph) * IP_W'(TABLE_SIZE) + (IP_W'(1) << 31);
    assign w_idx_full = w_idx_prod[IP_W-1:fmv_pkg::PHASE_W];
    assign w_idx      = (w_idx_full >= (IDX_W+1)'(TABLE_SIZE)) ? '0 : w_idx_full[IDX_W-1:0];

    // mix, round and saturate
    assign w_acc_next = (r_pair ? r_acc : '0) + r_prod[ACC_W-1:0];
    assign w_acc_rnd  = r_acc + (ACC_W'(1) << (SAMPLE_BITS - 1));
    assign w_rnd      = RND_W'(w_acc_rnd >>> SAMPLE_BITS);

    always_comb begin
        if (w_rnd[RND_W-1:fmv_pkg::OUT_W-1] == '0 ||
            w_rnd[RND_W-1:fmv_pkg::OUT_W-1] == '1) begin
            w_sat = w_rnd[fmv_pkg::OUT_W-1:0];
        end else if (w_rnd[RND_W-1]) begin
            w_sat = fmv_pkg::SAMPLE_MIN;
        end else begin
            w_sat = fmv_pkg::SAMPLE_MAX;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mult_op2     <= fmv_pkg::MULT_UNITY;
            r_mult_op3     <= fmv_pkg::MULT_UNITY;
            r_mult_op4     <= fmv_pkg::MULT_UNITY;
            r_depth_pair_a <= '0;
            r_depth_pair_b <= '0;
            r_level_op1    <= fmv_pkg::LEVEL_RESET;
            r_level_op3    <= fmv_pkg::LEVEL_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                fmv_pkg::CFG_MULT_OP2:     r_mult_op2     <= i_cfg_data[fmv_pkg::MULT_W-1:0];
                fmv_pkg::CFG_MULT_OP3:     r_mult_op3     <= i_cfg_data[fmv_pkg::MULT_W-1:0];
                fmv_pkg::CFG_MULT_OP4:     r_mult_op4     <= i_cfg_data[fmv_pkg::MULT_W-1:0];
                fmv_pkg::CFG_DEPTH_PAIR_A: r_depth_pair_a <= i_cfg_data;
                fmv_pkg::CFG_DEPTH_PAIR_B: r_depth_pair_b <= i_cfg_data;
                fmv_pkg::CFG_LEVEL_OP1:    r_level_op1    <= i_cfg_data[fmv_pkg::LEVEL_W-1:0];
                fmv_pkg::CFG_LEVEL_OP3:    r_level_op3    <= i_cfg_data[fmv_pkg::LEVEL_W-1:0];
                default: begin
                    // unused index, ignored
                end
            endcase
        end
    end

    // datapath payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_base <= i_base_increment;
        end
        if (w_mul_en) begin
            r_prod <= w_prod;
        end
        if (w_wr_en) begin
            r_ph <= w_wr_data;
        end
        if (r_state == ST_MIDX || r_state == ST_CIDX) begin
            r_idx <= w_idx;
        end
        if (r_state == ST_MSIN || r_state == ST_CSIN) begin
            r_sin <= w_sine[r_idx];
        end
        if (r_state == ST_MSIN) begin
            r_cph <= w_rd_ph + r_prod[39:8];
        end
        if (r_state == ST_ACC) begin
            r_acc <= w_acc_next;
        end
    end

    // sequencer, phase valid bits and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pair    <= 1'b0;
            r_ph_vld  <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_wr_en) begin
                r_ph_vld[w_wr_addr] <= 1'b1;
            end
            if (w_rd_en) begin
                r_rd_vld <= r_ph_vld[w_rd_addr];
            end
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_stall) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_pair  <= 1'b0;
                        r_state <= ST_MINC;
                    end
                end
                ST_MINC: r_state <= ST_MPH;
                ST_MPH:  r_state <= ST_MIDX;
                ST_MIDX: r_state <= ST_MSIN;
                ST_MSIN: r_state <= ST_DEP;
                ST_DEP:  r_state <= ST_CPH;
                ST_CPH:  r_state <= ST_CIDX;
                ST_CIDX: r_state <= ST_CSIN;
                ST_CSIN: r_state <= ST_LVL;
                ST_LVL:  r_state <= ST_ACC;
                ST_ACC: begin
                    if (r_pair) begin
                        r_state <= ST_RND;
                    end else begin
                        r_pair  <= 1'b1;
                        r_state <= ST_MINC;
                    end
                end
                ST_RND: begin
                    // wait here only while the previous sample is still held
                    if (w_out_load) begin
                        r_sample  <= w_sat;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule
